### rtl/core/tked_pkg.sv
package tked_pkg;

    localparam int PARAM_BUF_SIZE = 16;
    localparam int COUNT_W        = 5;

    // decode modes
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_ESC  = 2'd1;
    localparam logic [1:0] MODE_CSI  = 2'd2;
    localparam logic [1:0] MODE_SS3  = 2'd3;

    // action codes
    localparam logic [4:0] ACT_NONE      = 5'd0;
    localparam logic [4:0] ACT_UP        = 5'd1;
    localparam logic [4:0] ACT_DOWN      = 5'd2;
    localparam logic [4:0] ACT_TOP       = 5'd3;
    localparam logic [4:0] ACT_BOTTOM    = 5'd4;
    localparam logic [4:0] ACT_LINKPREV  = 5'd5;
    localparam logic [4:0] ACT_PGUP      = 5'd6;
    localparam logic [4:0] ACT_PGDN      = 5'd7;
    localparam logic [4:0] ACT_ESC       = 5'd8;
    localparam logic [4:0] ACT_LINKNEXT  = 5'd9;
    localparam logic [4:0] ACT_OPEN      = 5'd10;
    localparam logic [4:0] ACT_BKSP      = 5'd11;
    localparam logic [4:0] ACT_CHAR      = 5'd12;
    localparam logic [4:0] ACT_TAB1      = 5'd13;
    localparam logic [4:0] ACT_OMNIBOX   = 5'd22;
    localparam logic [4:0] ACT_NEWTAB    = 5'd23;
    localparam logic [4:0] ACT_CLOSETAB  = 5'd24;
    localparam logic [4:0] ACT_NEXTTAB   = 5'd25;
    localparam logic [4:0] ACT_PREVTAB   = 5'd26;
    localparam logic [4:0] ACT_RELOAD    = 5'd27;
    localparam logic [4:0] ACT_BMTOGGLE  = 5'd28;
    localparam logic [4:0] ACT_BOOKMARKS = 5'd29;
    localparam logic [4:0] ACT_HELP      = 5'd30;
    localparam logic [4:0] ACT_QUIT      = 5'd31;

    // byte codes
    localparam logic [7:0] KEY_ESC       = 8'h1B;
    localparam logic [7:0] KEY_TAB       = 8'h09;
    localparam logic [7:0] KEY_CR        = 8'h0D;
    localparam logic [7:0] KEY_LF        = 8'h0A;
    localparam logic [7:0] KEY_DEL       = 8'h7F;
    localparam logic [7:0] KEY_BS        = 8'h08;
    localparam logic [7:0] KEY_SPACE     = 8'h20;
    localparam logic [7:0] KEY_FINAL_LO  = 8'h40;
    localparam logic [7:0] KEY_FINAL_HI  = 8'h7E;
    localparam logic [7:0] KEY_LBRACKET  = 8'h5B;
    localparam logic [7:0] KEY_CAP_O     = 8'h4F;
    localparam logic [7:0] KEY_TILDE     = 8'h7E;
    localparam logic [7:0] KEY_DIGIT_1   = 8'h31;
    localparam logic [7:0] KEY_DIGIT_9   = 8'h39;

    typedef struct packed {
        logic [1:0]         mode;
        logic [COUNT_W-1:0] count;
        logic [7:0]         first_param;
    } dec_state_t;

    typedef struct packed {
        logic       emit;
        logic [4:0] action;
        logic [7:0] char_value;
    } dec_result_t;

endpackage

### rtl/core/tked_decode.sv
module tked_decode
    import tked_pkg::*;
(
    input  logic [7:0]  key_byte,
    input  logic        literal_mode,
    input  dec_state_t  state_cur,
    output dec_state_t  state_next,
    output dec_result_t result
);

    function automatic logic [4:0] letter_action(input logic [7:0] c);
        logic [4:0] a;
        begin
            unique case (c)
                8'h6A:   a = ACT_DOWN;      // j
                8'h6B:   a = ACT_UP;        // k
                8'h64:   a = ACT_PGDN;      // d
                8'h75:   a = ACT_PGUP;      // u
                8'h67:   a = ACT_TOP;       // g
                8'h47:   a = ACT_BOTTOM;    // G
                8'h6F:   a = ACT_OMNIBOX;   // o
                8'h74:   a = ACT_NEWTAB;    // t
                8'h77:   a = ACT_CLOSETAB;  // w
                8'h5D:   a = ACT_NEXTTAB;   // ]
                8'h5B:   a = ACT_PREVTAB;   // [
                8'h72:   a = ACT_RELOAD;    // r
                8'h62:   a = ACT_BMTOGGLE;  // b
                8'h42:   a = ACT_BOOKMARKS; // B
                8'h3F:   a = ACT_HELP;      // ?
                8'h71:   a = ACT_QUIT;      // q
                default: a = ACT_NONE;
            endcase
            return a;
        end
    endfunction

    function automatic logic [4:0] csi_action(input logic [7:0] fin,
                                              input logic [COUNT_W-1:0] cnt,
                                              input logic [7:0] par);
        logic [4:0] a;
        begin
            a = ACT_NONE;
            if (cnt == '0) begin
                unique case (fin)
                    8'h41:   a = ACT_UP;       // A
                    8'h42:   a = ACT_DOWN;     // B
                    8'h48:   a = ACT_TOP;      // H
                    8'h46:   a = ACT_BOTTOM;   // F
                    8'h5A:   a = ACT_LINKPREV; // Z
                    default: a = ACT_NONE;
                endcase
            end else if (fin == KEY_TILDE && cnt == COUNT_W'(1)) begin
                unique case (par)
                    8'h35:   a = ACT_PGUP;   // 5
                    8'h36:   a = ACT_PGDN;   // 6
                    8'h31:   a = ACT_TOP;    // 1
                    8'h34:   a = ACT_BOTTOM; // 4
                    default: a = ACT_NONE;
                endcase
            end
            return a;
        end
    endfunction

    logic [4:0] letter_act;
    logic       is_final;

    assign letter_act = letter_action(key_byte);
    assign is_final   = (key_byte >= KEY_FINAL_LO) && (key_byte <= KEY_FINAL_HI);

    always_comb begin
        state_next = state_cur;
        result     = '0;
        unique case (state_cur.mode)
            MODE_ESC: begin
                priority if (key_byte == KEY_LBRACKET) begin
                    state_next.mode  = MODE_CSI;
                    state_next.count = '0;
                end else if (key_byte == KEY_CAP_O) begin
                    state_next.mode = MODE_SS3;
                end else begin
                    state_next.mode = MODE_IDLE;
                    result.emit     = 1'b1;
                    result.action   = ACT_ESC;
                end
            end
            MODE_SS3: begin
                state_next.mode = MODE_IDLE;
                result.emit     = 1'b1;
                priority if (key_byte == 8'h48) begin
                    result.action = ACT_TOP;
                end else if (key_byte == 8'h46) begin
                    result.action = ACT_BOTTOM;
                end else begin
                    result.action = ACT_NONE;
                end
            end
            MODE_CSI: begin
                priority if (is_final) begin
                    state_next.mode = MODE_IDLE;
                    result.emit     = 1'b1;
                    result.action   = csi_action(key_byte, state_cur.count,
                                                 state_cur.first_param);
                end else if (state_cur.count < COUNT_W'(PARAM_BUF_SIZE)) begin
                    if (state_cur.count == '0) begin
                        state_next.first_param = key_byte;
                    end
                    state_next.count = state_cur.count + COUNT_W'(1);
                end else begin
                    // buffer full: drop the sequence silently
                    state_next.mode = MODE_IDLE;
                end
            end
            default: begin
                result.emit = 1'b1;
                priority if (key_byte == KEY_ESC) begin
                    state_next.mode = MODE_ESC;
                    result.emit     = 1'b0;
                end else if (key_byte == KEY_TAB) begin
                    result.action = ACT_LINKNEXT;
                end else if (key_byte == KEY_CR || key_byte == KEY_LF) begin
                    result.action = ACT_OPEN;
                end else if (key_byte == KEY_DEL || key_byte == KEY_BS) begin
                    result.action = ACT_BKSP;
                end else if (literal_mode && key_byte >= KEY_SPACE) begin
                    result.action     = ACT_CHAR;
                    result.char_value = key_byte;
                end else if (key_byte >= KEY_DIGIT_1 && key_byte <= KEY_DIGIT_9) begin
                    result.action = ACT_TAB1 + 5'(key_byte - KEY_DIGIT_1);
                end else if (letter_act != ACT_NONE) begin
                    result.action = letter_act;
                end else if (key_byte >= KEY_SPACE) begin
                    result.action     = ACT_CHAR;
                    result.char_value = key_byte;
                end else begin
                    result.action = ACT_NONE;
                end
            end
        endcase
    end

endmodule

### rtl/core/terminal_key_escape_decoder_unit.sv
// Pipeline: a word accepted on s_ waits in the input register, then is decoded
//   into the result register, from which it shows on m_.
// Throughput: one word per cycle unless a full result register waits on m_ready;
//   the mode register is read and written as each word decodes, so consecutive bytes never wait on each other.
// Reset: aresetn is synchronous, active low; it clears the mode, the CSI
//   parameter count, literal_mode and both valid flags.
module terminal_key_escape_decoder_unit
    import tked_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_key_byte,

    output logic       m_valid,
    input  logic       m_ready,
    output logic [4:0] m_action,
    output logic [7:0] m_char_value,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_literal_mode
);

    // input stage
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;

    // decoder state
    dec_state_t  state_reg;
    dec_state_t  state_next;
    dec_result_t dec_res;

    // configuration
    logic        literal_mode_reg;

    // result stage
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [4:0]  out_action_reg;
    logic [7:0]  out_char_reg;

    logic        advance;

    tked_decode u_decode (
        .key_byte     (in_byte_reg),
        .literal_mode (literal_mode_reg),
        .state_cur    (state_reg),
        .state_next   (state_next),
        .result       (dec_res)
    );

    // Advance the held word when its result has room: either it yields no
    // result, or the result register is empty or draining this cycle.
    assign advance = in_valid_reg &&
                     (!dec_res.emit || !out_valid_reg || m_ready);

    // Take a new word whenever the input register is free or moving on.
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance && dec_res.emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // control state; the first CSI parameter is not reset, it is always
    // written before it is read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            literal_mode_reg <= 1'b0;
            state_reg.mode   <= MODE_IDLE;
            state_reg.count  <= '0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                state_reg <= state_next;
            end
            if (cfg_valid) begin
                literal_mode_reg <= cfg_literal_mode;
            end
        end
    end

    // payload: hold until the next word or result replaces it
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_key_byte;
        end
        if (advance && dec_res.emit) begin
            out_action_reg <= dec_res.action;
            out_char_reg   <= dec_res.char_value;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_action     = out_action_reg;
    assign m_char_value = out_char_reg;

endmodule

### verif/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tked_pkg::*;

    // One decoded key event as it leaves on m_.
    typedef struct packed {
        logic [4:0] action;
        logic [7:0] char_value;
    } key_event_t;

    // One row of the directed stimulus: a key byte, how many times to send it,
    // and, where the answer is obvious, the event it must give.
    typedef struct {
        logic [7:0] key;
        int         reps;
        bit         pinned;
        logic [4:0] action;
        logic [7:0] char_value;
    } key_row_t;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_BYTES   = 480;
    localparam int N_DIRECTED    = 25;
    localparam int REPORT_MAX    = 10;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_key_byte;
    logic       m_valid;
    logic       m_ready;
    logic [4:0] m_action;
    logic [7:0] m_char_value;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       cfg_literal_mode;

    terminal_key_escape_decoder_unit u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_key_byte       (s_key_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_action         (m_action),
        .m_char_value     (m_char_value),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_literal_mode (cfg_literal_mode)
    );

    // 2 ns clock period.
    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Decoder shadow: mode, CSI parameter count and first parameter, plus
    // the literal_mode setting as last written. All start at reset values.
    // ------------------------------------------------------------------
    logic [1:0] key_mode    = MODE_IDLE;
    logic [4:0] csi_count   = '0;
    logic [7:0] csi_first   = '0;
    logic       literal_on  = 1'b0;

    key_event_t pending_events[$];

    // Tallies for the closing summary.
    int bytes_sent      = 0;
    int events_seen     = 0;
    int cfg_writes      = 0;
    int lone_esc_hits   = 0;
    int ss3_tails       = 0;
    int csi_finals      = 0;
    int csi_overflows   = 0;
    int mismatches      = 0;
    int cycle_count     = 0;

    // Side-band from the sender to the monitor: the event that the word now
    // on s_ must give, when a directed row types it in.
    bit         row_pinned = 1'b0;
    logic [4:0] row_action = ACT_NONE;
    logic [7:0] row_char   = 8'h00;

    // Idle ranges per phase, and the request for the long receiver stall.
    int send_gap_max = 10;
    int recv_gap_max = 10;
    bit hold_req     = 1'b0;

    // Advance the shadow by one key byte and say which event, if any, it gives.
    function automatic void decode_key(input logic [7:0] kb, output bit has_event,
                                       output key_event_t ev);
        has_event     = 1'b1;
        ev.action     = ACT_NONE;
        ev.char_value = 8'h00;
        case (key_mode)
            MODE_ESC: begin
                if (kb == KEY_LBRACKET) begin
                    key_mode  = MODE_CSI;
                    csi_count = '0;
                    has_event = 1'b0;
                end else if (kb == KEY_CAP_O) begin
                    key_mode  = MODE_SS3;
                    has_event = 1'b0;
                end else begin
                    // lone ESC: the byte after it is swallowed
                    key_mode  = MODE_IDLE;
                    ev.action = ACT_ESC;
                    lone_esc_hits++;
                end
            end
            MODE_SS3: begin
                key_mode = MODE_IDLE;
                ss3_tails++;
                if (kb == "H")
                    ev.action = ACT_TOP;
                else if (kb == "F")
                    ev.action = ACT_BOTTOM;
            end
            MODE_CSI: begin
                if (kb >= KEY_FINAL_LO && kb <= KEY_FINAL_HI) begin
                    key_mode = MODE_IDLE;
                    csi_finals++;
                    if (csi_count == 0) begin
                        case (kb)
                            "A":     ev.action = ACT_UP;
                            "B":     ev.action = ACT_DOWN;
                            "H":     ev.action = ACT_TOP;
                            "F":     ev.action = ACT_BOTTOM;
                            "Z":     ev.action = ACT_LINKPREV;
                            default: ev.action = ACT_NONE;
                        endcase
                    end else if (kb == KEY_TILDE && csi_count == 1) begin
                        case (csi_first)
                            "5":     ev.action = ACT_PGUP;
                            "6":     ev.action = ACT_PGDN;
                            "1":     ev.action = ACT_TOP;
                            "4":     ev.action = ACT_BOTTOM;
                            default: ev.action = ACT_NONE;
                        endcase
                    end
                end else begin
                    has_event = 1'b0;
                    if (csi_count < PARAM_BUF_SIZE) begin
                        if (csi_count == 0)
                            csi_first = kb;
                        csi_count = csi_count + 5'd1;
                    end else begin
                        // buffer full: drop the whole sequence silently
                        key_mode = MODE_IDLE;
                        csi_overflows++;
                    end
                end
            end
            default: begin
                if (kb == KEY_ESC) begin
                    key_mode  = MODE_ESC;
                    has_event = 1'b0;
                end else if (kb == KEY_TAB) begin
                    ev.action = ACT_LINKNEXT;
                end else if (kb == KEY_CR || kb == KEY_LF) begin
                    ev.action = ACT_OPEN;
                end else if (kb == KEY_DEL || kb == KEY_BS) begin
                    ev.action = ACT_BKSP;
                end else if (literal_on && kb >= KEY_SPACE) begin
                    ev.action     = ACT_CHAR;
                    ev.char_value = kb;
                end else if (kb >= KEY_DIGIT_1 && kb <= KEY_DIGIT_9) begin
                    ev.action = ACT_TAB1 + 5'(kb - KEY_DIGIT_1);
                end else begin
                    case (kb)
                        "j": ev.action = ACT_DOWN;
                        "k": ev.action = ACT_UP;
                        "d": ev.action = ACT_PGDN;
                        "u": ev.action = ACT_PGUP;
                        "g": ev.action = ACT_TOP;
                        "G": ev.action = ACT_BOTTOM;
                        "o": ev.action = ACT_OMNIBOX;
                        "t": ev.action = ACT_NEWTAB;
                        "w": ev.action = ACT_CLOSETAB;
                        "]": ev.action = ACT_NEXTTAB;
                        "[": ev.action = ACT_PREVTAB;
                        "r": ev.action = ACT_RELOAD;
                        "b": ev.action = ACT_BMTOGGLE;
                        "B": ev.action = ACT_BOOKMARKS;
                        "?": ev.action = ACT_HELP;
                        "q": ev.action = ACT_QUIT;
                        default: begin
                            // unmapped: printable gives a character, control gives none
                            if (kb >= KEY_SPACE) begin
                                ev.action     = ACT_CHAR;
                                ev.char_value = kb;
                            end
                        end
                    endcase
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Monitor: everything is sampled at the rising edge. Predict first, then
    // check, so a result never races the word that caused it.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        bit         has_event;
        key_event_t predicted;
        key_event_t got;
        key_event_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                decode_key(s_key_byte, has_event, predicted);
                // a typed-in row overrides the shadow's answer, the state still advances
                if (row_pinned) begin
                    has_event            = 1'b1;
                    predicted.action     = row_action;
                    predicted.char_value = row_char;
                end
                if (has_event)
                    pending_events.push_back(predicted);
            end
            if (cfg_valid && cfg_ready)
                literal_on = cfg_literal_mode;
            if (m_valid && m_ready) begin
                got.action     = m_action;
                got.char_value = m_char_value;
                events_seen++;
                if (pending_events.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("unexpected event: action %0d char %02h",
                                 got.action, got.char_value);
                end else begin
                    want = pending_events.pop_front();
                    if (got.action !== want.action || got.char_value !== want.char_value) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("event %0d: expected action %0d char %02h, got action %0d char %02h",
                                     events_seen, want.action, want.char_value,
                                     got.action, got.char_value);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: count cycles and end the run if it hangs.
    // ------------------------------------------------------------------
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d events still pending",
                 cycle_count, pending_events.size());
        $display("[terminal_key_escape_decoder_unit] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: draw a stall per word, hold m_ready low for it, then take the
    // word. On request, hold off for a long stretch so the block backs up.
    // ------------------------------------------------------------------
    initial begin
        int gap;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            gap = $urandom_range(recv_gap_max, 0);
            if (hold_req) begin
                gap      = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (gap > 0) begin
                m_ready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            @(negedge aclk);
        end
    end

    // Offer one key word after a random gap, hold it until taken. Called and
    // returns at a falling edge; s_valid stays high when the next gap is zero.
    task automatic send_byte(input logic [7:0] kb, input bit pin = 1'b0,
                             input logic [4:0] act = ACT_NONE,
                             input logic [7:0] chr = 8'h00);
        int gap;
        gap = $urandom_range(send_gap_max, 0);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_key_byte = kb;
        row_pinned = pin;
        row_action = act;
        row_char   = chr;
        s_valid    = 1'b1;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
        @(negedge aclk);
    endtask

    // Drain the block before touching the register: no event pending, then a
    // SETTLE_CYCLES wait for words that give no event but may still be in flight.
    task automatic wait_idle();
        s_valid    = 1'b0;
        row_pinned = 1'b0;
        while (pending_events.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_literal(input logic val);
        cfg_literal_mode = val;
        cfg_valid        = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_writes++;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // One random sequence: mostly well-formed CSI / SS3 / key traffic with
    // random content, the rest lone ESC and raw noise.
    task automatic send_random_sequence();
        string      hot_keys = "jkdugGotw][rbB?q123456789";
        string      csi_params = "1456";
        string      csi_ends = "ABHFZ~";
        int         pick;
        int         n;
        logic [7:0] kb;
        pick = $urandom_range(99, 0);
        if (pick < 40) begin
            case ($urandom_range(3, 0))
                0:       kb = 8'($urandom_range(255, 0));
                1:       kb = 8'($urandom_range(8'h1F, 0));
                2:       kb = hot_keys[$urandom_range(hot_keys.len() - 1, 0)];
                default: kb = 8'($urandom_range(8'h7E, 8'h20));
            endcase
            send_byte(kb);
        end else if (pick < 75) begin
            send_byte(KEY_ESC);
            send_byte(KEY_LBRACKET);
            // now and then run the parameter buffer up to and past full
            if ($urandom_range(9, 0) == 0)
                n = $urandom_range(PARAM_BUF_SIZE + 2, PARAM_BUF_SIZE - 2);
            else
                n = $urandom_range(2, 0);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(1, 0) != 0)
                    kb = csi_params[$urandom_range(csi_params.len() - 1, 0)];
                else
                    kb = 8'($urandom_range(255, 0));
                // keep parameters out of the final-byte range
                if (kb >= KEY_FINAL_LO && kb <= KEY_FINAL_HI)
                    kb = kb ^ 8'h80;
                send_byte(kb);
            end
            if ($urandom_range(2, 0) != 0)
                kb = csi_ends[$urandom_range(csi_ends.len() - 1, 0)];
            else
                kb = 8'($urandom_range(KEY_FINAL_HI, KEY_FINAL_LO));
            send_byte(kb);
        end else if (pick < 90) begin
            send_byte(KEY_ESC);
            send_byte(KEY_CAP_O);
            case ($urandom_range(2, 0))
                0:       send_byte("H");
                1:       send_byte("F");
                default: send_byte(8'($urandom_range(255, 0)));
            endcase
        end else begin
            send_byte(KEY_ESC);
            send_byte(8'($urandom_range(255, 0)));
        end
    endtask

    // One random phase at a given literal_mode and idle profile.
    task automatic run_phase(input logic lit, input int s_max, input int r_max,
                             input bit with_hold);
        int start;
        bit held;
        held = 1'b0;
        wait_idle();
        write_literal(lit);
        send_gap_max = s_max;
        recv_gap_max = r_max;
        start        = bytes_sent;
        while (bytes_sent < start + PHASE_BYTES) begin
            // stall the receiver once, partway in, while words keep coming
            if (with_hold && !held && bytes_sent >= start + PHASE_BYTES / 2) begin
                hold_req     = 1'b1;
                held         = 1'b1;
                send_gap_max = 0;
            end
            send_random_sequence();
            if (held)
                send_gap_max = s_max;
        end
    endtask

    // Directed rows: extremes, the key map, then each escape special case.
    key_row_t directed_rows [N_DIRECTED] = '{
        '{8'h00,        1, 1'b1, ACT_NONE,     8'h00},
        '{8'hFF,        1, 1'b1, ACT_CHAR,     8'hFF},
        '{KEY_TAB,      1, 1'b1, ACT_LINKNEXT, 8'h00},
        '{KEY_CR,       1, 1'b1, ACT_OPEN,     8'h00},
        '{KEY_LF,       1, 1'b1, ACT_OPEN,     8'h00},
        '{KEY_DEL,      1, 1'b1, ACT_BKSP,     8'h00},
        '{KEY_BS,       1, 1'b1, ACT_BKSP,     8'h00},
        '{KEY_DIGIT_1,  1, 1'b1, ACT_TAB1,     8'h00},
        '{"q",          1, 1'b1, ACT_QUIT,     8'h00},
        // lone ESC swallows the next byte
        '{KEY_ESC,      1, 1'b0, ACT_NONE,     8'h00},
        '{"x",          1, 1'b1, ACT_ESC,      8'h00},
        // SS3 tail, mapped and unmapped
        '{KEY_ESC,      1, 1'b0, ACT_NONE,     8'h00},
        '{KEY_CAP_O,    1, 1'b0, ACT_NONE,     8'h00},
        '{"H",          1, 1'b1, ACT_TOP,      8'h00},
        '{KEY_ESC,      1, 1'b0, ACT_NONE,     8'h00},
        '{KEY_CAP_O,    1, 1'b0, ACT_NONE,     8'h00},
        '{"z",          1, 1'b1, ACT_NONE,     8'h00},
        // CSI with one parameter and tilde
        '{KEY_ESC,      1, 1'b0, ACT_NONE,     8'h00},
        '{KEY_LBRACKET, 1, 1'b0, ACT_NONE,     8'h00},
        '{"5",          1, 1'b0, ACT_NONE,     8'h00},
        '{KEY_TILDE,    1, 1'b1, ACT_PGUP,     8'h00},
        // CSI overflow: one parameter past the buffer drops the sequence,
        // so the final byte lands in idle as a plain character
        '{KEY_ESC,      1, 1'b0, ACT_NONE,     8'h00},
        '{KEY_LBRACKET, 1, 1'b0, ACT_NONE,     8'h00},
        '{"0", PARAM_BUF_SIZE + 1, 1'b0, ACT_NONE, 8'h00},
        '{"A",          1, 1'b1, ACT_CHAR,     8'h41}
    };

    // ------------------------------------------------------------------
    // Main sequence: reset, directed rows, then four random phases that walk
    // literal_mode through both values with different idle profiles.
    // ------------------------------------------------------------------
    initial begin
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_key_byte       = 8'h00;
        cfg_valid        = 1'b0;
        cfg_literal_mode = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed rows at the reset setting of literal_mode.
        foreach (directed_rows[i]) begin
            for (int r = 0; r < directed_rows[i].reps; r++)
                send_byte(directed_rows[i].key, directed_rows[i].pinned,
                          directed_rows[i].action, directed_rows[i].char_value);
        end

        // Both sides idle, with one long receiver stall.
        run_phase(1'b1, 10, 10, 1'b1);
        // Back to back on both sides.
        run_phase(1'b0, 0, 0, 1'b0);
        // Only the sender idles.
        run_phase(1'b1, 10, 0, 1'b0);
        // Only the receiver stalls.
        run_phase(1'b0, 0, 10, 1'b0);

        // Drain, then wait out DRAIN_CYCLES more for stray events.
        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("ran %0d key bytes, %0d events, %0d literal_mode writes, %0d mismatches",
                 bytes_sent, events_seen, cfg_writes, mismatches);
        $display("lone ESC %0d, SS3 tails %0d, CSI finals %0d, CSI overflows %0d",
                 lone_esc_hits, ss3_tails, csi_finals, csi_overflows);
        if (mismatches == 0 && pending_events.size() == 0) begin
            $display("[terminal_key_escape_decoder_unit] OK");
        end else begin
            $display("[terminal_key_escape_decoder_unit] ERROR");
        end
        $finish;
    end

endmodule
